// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the gate-to-trigger RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A same-cycle implication checked outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// A next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/gttfc_pkg.sv =====
// Package with the shared types and constants of the gate-to-trigger block.
`timescale 1ns / 1ps

package gttfc_pkg;

   localparam int MAX_CHANNELS         = 4;
   localparam int DEFAULT_NUM_CHANNELS = 4;
   localparam int TIMER_WIDTH          = 8;
   localparam int COUNT_WIDTH          = 8;
   localparam int MODES_WIDTH          = 2 * MAX_CHANNELS;

   localparam logic [TIMER_WIDTH-1:0] TRIG_LENGTH_RESET = 8'd39;
   localparam logic [COUNT_WIDTH-1:0] COUNTDOWN_RESET   = 8'd255;

   localparam logic OP_POLL = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [2:0] PHASE_START        = 3'd0;
   localparam logic [2:0] PHASE_READ_HIGH    = 3'd1;
   localparam logic [2:0] PHASE_READ_LOW     = 3'd2;
   localparam logic [2:0] PHASE_DECODE_FIRST = 3'd3;
   localparam logic [2:0] PHASE_DECODE_LAST  = 3'd6;

   typedef enum logic [1:0] {
      MODE_FALL     = 2'd0,
      MODE_RISEFALL = 2'd1,
      MODE_INVGATE  = 2'd2
   } mode_type;

   typedef struct packed {
      logic                   poll;
      logic                   tick;
      logic [TIMER_WIDTH-1:0] pulse_len;
   } lane_ctl_type;

   typedef struct packed {
      logic                          drive;
      mode_type [MAX_CHANNELS-1:0]   modes;
   } seq_out_type;

endpackage

// ===== rtl/gate_to_trigger_four_channel.sv =====
// Top level of the four-channel gate-to-trigger converter.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_stall   operation, gate_in, sense_in
//   rsp      out        rsp_valid/rsp_stall   trig_out, sense_drive, switch_modes
//   csr      in         csr_valid/csr_ready   data (pulse length)
//
// One request per cycle while req_stall is low; each accepted response is registered.
// All channel lanes and the sense sequencer update in the accepting cycle.
// A two-deep output stage (register plus skid) decouples response stalls.
// Reset is synchronous; the pulse length returns to 39 and the modes to rise-and-fall.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gate_to_trigger_four_channel #(
   parameter int NUM_CHANNELS = gttfc_pkg::DEFAULT_NUM_CHANNELS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_operation,
   input  logic [gttfc_pkg::MAX_CHANNELS-1:0]  req_gate_in,
   input  logic [gttfc_pkg::MAX_CHANNELS-1:0]  req_sense_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [gttfc_pkg::MAX_CHANNELS-1:0]  rsp_trig_out,
   output logic                                rsp_sense_drive,
   output logic [gttfc_pkg::MODES_WIDTH-1:0]   rsp_switch_modes,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gttfc_pkg::TIMER_WIDTH-1:0]   csr_data
);

   typedef struct packed {
      logic [gttfc_pkg::MAX_CHANNELS-1:0] trig;
      logic                               drive;
      logic [gttfc_pkg::MODES_WIDTH-1:0]  modes;
   } result_type;

   logic [gttfc_pkg::TIMER_WIDTH-1:0]  pulse_len_ff, pulse_len_in;
   logic                               take;
   gttfc_pkg::lane_ctl_type            lane_ctl;
   gttfc_pkg::seq_out_type             seq_next;
   logic [gttfc_pkg::MAX_CHANNELS-1:0] lane_out;
   result_type                         result;
   logic                               out_valid_ff, out_valid_in;
   result_type                         out_ff, out_in;
   logic                               skid_valid_ff, skid_valid_in;
   result_type                         skid_ff, skid_in;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign take      = req_valid && !skid_valid_ff;

   assign pulse_len_in = (csr_valid && csr_ready) ? csr_data : pulse_len_ff;

   assign lane_ctl.poll      = take && (req_operation == gttfc_pkg::OP_POLL);
   assign lane_ctl.tick      = take && (req_operation == gttfc_pkg::OP_TICK);
   assign lane_ctl.pulse_len = pulse_len_ff;

   gttfc_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .step     (lane_ctl.poll),
      .sense    (req_sense_in),
      .seq_next (seq_next)
   );

   for (genvar i = 0; i < gttfc_pkg::MAX_CHANNELS; i++) begin : g_lane
      if (i < NUM_CHANNELS) begin : g_on
         gttfc_lane u_lane (
            .clock    (clock),
            .reset    (reset),
            .ctl      (lane_ctl),
            .gate     (req_gate_in[i]),
            .mode     (seq_next.modes[i]),
            .out_next (lane_out[i])
         );
      end else begin : g_off
         assign lane_out[i] = 1'b0;
      end
   end

   always_comb begin
      result.trig  = lane_out;
      result.drive = seq_next.drive;
      result.modes = '0;
      for (int k = 0; k < gttfc_pkg::MAX_CHANNELS; k++) begin
         if (k < NUM_CHANNELS) begin
            result.modes[2*k +: 2] = seq_next.modes[k];
         end
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_valid_ff && !rsp_stall) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else if (take) begin
            out_in = result;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (!out_valid_ff) begin
         if (take) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end
      end else if (take) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_len_ff  <= gttfc_pkg::TRIG_LENGTH_RESET;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         pulse_len_ff  <= pulse_len_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_trig_out     = out_ff.trig;
   assign rsp_sense_drive  = out_ff.drive;
   assign rsp_switch_modes = out_ff.modes;

   `ASSERT_IMPLY(a_skid_needs_out, clock, reset, skid_valid_ff, out_valid_ff,
      "Skid entry held while the output register is empty.")
   `ASSERT_NEXT(a_skid_fill, clock, reset, take && out_valid_ff && rsp_stall, skid_valid_ff,
      "Request accepted under a stalled response was not kept in the skid stage.")
   `ASSERT_NEXT(a_skid_drain, clock, reset, skid_valid_ff && !rsp_stall,
      out_valid_ff && !skid_valid_ff,
      "Skid entry was not moved into the output register.")

endmodule

// ===== rtl/gttfc_sequencer.sv =====
// Switch-sense sequencer that reads the mode switches and decodes channel modes.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gttfc_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  logic [gttfc_pkg::MAX_CHANNELS-1:0]  sense,
   output gttfc_pkg::seq_out_type              seq_next
);

   logic [gttfc_pkg::COUNT_WIDTH-1:0]  countdown_ff, countdown_in;
   logic [2:0]                         phase_ff, phase_in;
   logic [gttfc_pkg::MAX_CHANNELS-1:0] rd_high_ff, rd_high_in;
   logic [gttfc_pkg::MAX_CHANNELS-1:0] rd_low_ff, rd_low_in;
   logic                               drive_ff, drive_in;
   gttfc_pkg::mode_type [gttfc_pkg::MAX_CHANNELS-1:0] mode_ff, mode_in;

   always_comb begin
      logic [2:0] phase_inc;
      logic [1:0] dec_idx;
      countdown_in = countdown_ff;
      phase_in     = phase_ff;
      rd_high_in   = rd_high_ff;
      rd_low_in    = rd_low_ff;
      drive_in     = drive_ff;
      mode_in      = mode_ff;
      phase_inc    = phase_ff + 3'd1;
      dec_idx      = 2'(phase_inc - gttfc_pkg::PHASE_DECODE_FIRST);
      if (step) begin
         countdown_in = countdown_ff - 1'b1;
         if (countdown_in == '0) begin
            phase_in = phase_inc;
            if (phase_inc == gttfc_pkg::PHASE_READ_HIGH) begin
               rd_high_in = sense;
               drive_in   = 1'b0;
            end else if (phase_inc == gttfc_pkg::PHASE_READ_LOW) begin
               rd_low_in = sense;
               drive_in  = 1'b1;
            end else if (phase_inc >= gttfc_pkg::PHASE_DECODE_FIRST &&
                         phase_inc <= gttfc_pkg::PHASE_DECODE_LAST) begin
               for (int k = 0; k < gttfc_pkg::MAX_CHANNELS; k++) begin
                  if (dec_idx == 2'(k)) begin
                     if (!rd_high_ff[k]) begin
                        mode_in[k] = gttfc_pkg::MODE_FALL;
                     end else if (rd_low_ff[k]) begin
                        mode_in[k] = gttfc_pkg::MODE_RISEFALL;
                     end else begin
                        mode_in[k] = gttfc_pkg::MODE_INVGATE;
                     end
                  end
               end
               if (phase_inc == gttfc_pkg::PHASE_DECODE_LAST) begin
                  phase_in = gttfc_pkg::PHASE_START;
               end
            end
         end
      end
      seq_next.drive = drive_in;
      seq_next.modes = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         countdown_ff <= gttfc_pkg::COUNTDOWN_RESET;
         phase_ff     <= gttfc_pkg::PHASE_START;
         rd_high_ff   <= '0;
         rd_low_ff    <= '0;
         drive_ff     <= 1'b1;
         mode_ff      <= {gttfc_pkg::MAX_CHANNELS{gttfc_pkg::MODE_RISEFALL}};
      end else begin
         countdown_ff <= countdown_in;
         phase_ff     <= phase_in;
         rd_high_ff   <= rd_high_in;
         rd_low_ff    <= rd_low_in;
         drive_ff     <= drive_in;
         mode_ff      <= mode_in;
      end
   end

   `ASSERT_AT(a_phase_range, clock, reset, phase_ff <= gttfc_pkg::PHASE_DECODE_LAST,
      "Sense phase left the six-phase range.")
   `ASSERT_NEXT(a_count_hold, clock, reset, !step, $stable(countdown_ff),
      "Sense countdown moved without a poll.")
   `ASSERT_NEXT(a_phase_hold, clock, reset, step && countdown_ff != 8'd1, $stable(phase_ff),
      "Sense phase moved before the countdown reached zero.")

endmodule

// ===== rtl/gttfc_lane.sv =====
// One channel lane: gate edge detection, pulse timer and timeout.
`timescale 1ns / 1ps

module gttfc_lane (
   input  logic                    clock,
   input  logic                    reset,
   input  gttfc_pkg::lane_ctl_type ctl,
   input  logic                    gate,
   input  gttfc_pkg::mode_type     mode,
   output logic                    out_next
);

   logic                              gate_was_ff, gate_was_in;
   logic                              out_ff, out_in;
   logic [gttfc_pkg::TIMER_WIDTH-1:0] timer_ff, timer_in;

   always_comb begin
      gate_was_in = gate_was_ff;
      out_in      = out_ff;
      timer_in    = timer_ff;
      if (ctl.tick) begin
         timer_in = timer_ff + 1'b1;
      end else if (ctl.poll) begin
         if (gate && !gate_was_ff) begin
            gate_was_in = 1'b1;
            if (mode == gttfc_pkg::MODE_RISEFALL) begin
               out_in   = 1'b1;
               timer_in = '0;
            end else if (mode == gttfc_pkg::MODE_INVGATE) begin
               out_in = 1'b0;
            end
         end else if (!gate && gate_was_ff) begin
            gate_was_in = 1'b0;
            out_in      = 1'b1;
            timer_in    = '0;
         end
         if (mode != gttfc_pkg::MODE_INVGATE && out_in && timer_in > ctl.pulse_len) begin
            out_in = 1'b0;
         end
      end
      out_next = out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_was_ff <= 1'b0;
         out_ff      <= 1'b0;
         timer_ff    <= '0;
      end else begin
         gate_was_ff <= gate_was_in;
         out_ff      <= out_in;
         timer_ff    <= timer_in;
      end
   end

endmodule
